// ----- hdl/aes_key_expansion_macros.svh -----
// ----------------------------------------------------------------------------
// AES key expansion assertion macros
// Shared concurrent assertion forms used by the key expansion RTL.
// ----------------------------------------------------------------------------
`ifndef AES_KEY_EXPANSION_MACROS_SVH
`define AES_KEY_EXPANSION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AKE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AKE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/aeske_pkg.sv -----
// ----------------------------------------------------------------------------
// AES key expansion package
// Key size codes, the AES S-box, the round constants and schedule helpers.
// ----------------------------------------------------------------------------
package aeske_pkg;

    typedef logic [31:0] word_t;
    typedef logic [1:0]  key_mode_t;
    typedef logic [5:0]  word_idx_t;

    localparam key_mode_t KEY_MODE_128 = 2'd0;
    localparam key_mode_t KEY_MODE_192 = 2'd1;
    localparam key_mode_t KEY_MODE_256 = 2'd2;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic word_t sub_word(input word_t w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] round_const(input logic [3:0] idx);
        logic [7:0] rc;
        unique case (idx)
            4'd1:    rc = 8'h01;
            4'd2:    rc = 8'h02;
            4'd3:    rc = 8'h04;
            4'd4:    rc = 8'h08;
            4'd5:    rc = 8'h10;
            4'd6:    rc = 8'h20;
            4'd7:    rc = 8'h40;
            4'd8:    rc = 8'h80;
            4'd9:    rc = 8'h1b;
            4'd10:   rc = 8'h36;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

    // Key length in words; the unused code behaves as a 256-bit key.
    function automatic logic [3:0] key_words(input key_mode_t mode);
        logic [3:0] nk;
        unique case (mode)
            KEY_MODE_128: nk = 4'd4;
            KEY_MODE_192: nk = 4'd6;
            default:      nk = 4'd8;
        endcase
        return nk;
    endfunction

    // Index of the final word of the schedule: 43, 51 or 59.
    function automatic word_idx_t last_index(input key_mode_t mode);
        word_idx_t idx;
        unique case (mode)
            KEY_MODE_128: idx = 6'd43;
            KEY_MODE_192: idx = 6'd51;
            default:      idx = 6'd59;
        endcase
        return idx;
    endfunction

endpackage

// ----- hdl/aeske_ram.sv -----
// ----------------------------------------------------------------------------
// AES key expansion RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module aeske_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/aes_key_expansion.sv -----
// ----------------------------------------------------------------------------
// AES key expansion
// Key schedule for 128-, 192- and 256-bit keys with a shared S-box.
// ----------------------------------------------------------------------------
// Usage: select the key size through cfg_we/cfg_wdata while the block is idle
// (0 = 128-bit, 1 = 192-bit, 2 = 256-bit, 3 acts as 256-bit). Then send the
// cipher key one 32-bit word at a time on s_tdata, first key byte in the top
// byte. Every key word is echoed on the master side in the cycle after it is
// taken. After the last key word the block produces the rest of the schedule,
// up to 44, 52 or 60 words, with m_tuser carrying the word index and m_tlast
// marking the final word.
// Flow: key words can be taken back to back while the output register is
// free. For each generated word, ST_READ reads the word one key length back
// from the 8-entry window RAM and ST_CALC computes and stores the new word.
// Reset: aresetn clears the word count, round constant index and key size to
// their initial values; the window RAM is not cleared.
// Stalls: one output register sits on the master side. While it is full and
// m_tready is low, generation waits and s_tready stays low.
// ----------------------------------------------------------------------------
module aes_key_expansion
    import aeske_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,      // key_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,        // key_word[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,        // round_word[31:0]
    output logic [5:0]  m_tuser,        // word_index[5:0]
    output logic        m_tlast         // final_word
);

    `include "aes_key_expansion_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC
    } state_t;

    state_t     state_reg, state_next;
    key_mode_t  mode_reg;
    word_idx_t  wc_reg, wc_next;
    logic [3:0] rci_reg, rci_next;
    logic [2:0] pos_reg, pos_next;
    word_t      prev_reg, prev_next;
    logic       m_valid_reg, m_valid_next;
    word_t      m_data_reg, m_data_next;
    word_idx_t  m_user_reg, m_user_next;
    logic       m_last_reg, m_last_next;

    logic       ram_we;
    logic [2:0] ram_waddr;
    word_t      ram_wdata;
    logic [2:0] ram_raddr;
    word_t      ram_rdata;

    logic [3:0] nk;
    logic       out_free;
    logic       in_accept;
    logic       restart;
    word_idx_t  eff_wc;
    word_idx_t  eff_wc_inc;
    word_t      temp_word;
    word_t      new_word;
    logic       is_last;

    aeske_ram #(
        .WIDTH (32),
        .DEPTH (8)
    ) u_window (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign nk        = key_words(mode_reg);
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_accept = s_tvalid && s_tready;

    // A count already at or past the key length means the key size shrank
    // during loading, so the incoming word starts a new key.
    assign restart    = wc_reg >= {2'b00, nk};
    assign eff_wc     = restart ? 6'd0 : wc_reg;
    assign eff_wc_inc = eff_wc + 6'd1;

    // Word i - Nk lives at (i - Nk) mod 8; for Nk = 8 this is i mod 8 itself.
    assign ram_raddr = wc_reg[2:0] - nk[2:0];

    always_comb begin
        temp_word = prev_reg;
        if (pos_reg == 3'd0) begin
            temp_word = sub_word({prev_reg[23:0], prev_reg[31:24]})
                      ^ {round_const(rci_reg), 24'h000000};
        end else if (nk == 4'd8 && pos_reg == 3'd4) begin
            temp_word = sub_word(prev_reg);
        end
    end

    assign new_word = ram_rdata ^ temp_word;
    assign is_last  = wc_reg == last_index(mode_reg);

    always_comb begin
        state_next   = state_reg;
        wc_next      = wc_reg;
        rci_next     = rci_reg;
        pos_next     = pos_reg;
        prev_next    = prev_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        ram_we       = 1'b0;
        ram_waddr    = wc_reg[2:0];
        ram_wdata    = new_word;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    ram_we       = 1'b1;
                    ram_waddr    = eff_wc[2:0];
                    ram_wdata    = s_tdata;
                    prev_next    = s_tdata;
                    m_valid_next = 1'b1;
                    m_data_next  = s_tdata;
                    m_user_next  = eff_wc;
                    m_last_next  = 1'b0;
                    wc_next      = eff_wc_inc;
                    if (restart) begin
                        rci_next = 4'd1;
                    end
                    if (eff_wc_inc == {2'b00, nk}) begin
                        pos_next   = 3'd0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_CALC;
            end
            ST_CALC: begin
                if (out_free) begin
                    ram_we       = 1'b1;
                    prev_next    = new_word;
                    m_valid_next = 1'b1;
                    m_data_next  = new_word;
                    m_user_next  = wc_reg;
                    m_last_next  = is_last;
                    if (pos_reg == 3'd0) begin
                        rci_next = rci_reg + 4'd1;
                    end
                    if (is_last) begin
                        wc_next    = 6'd0;
                        rci_next   = 4'd1;
                        state_next = ST_IDLE;
                    end else begin
                        wc_next    = wc_reg + 6'd1;
                        pos_next   = ({1'b0, pos_reg} + 4'd1 == nk) ? 3'd0 : pos_reg + 3'd1;
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= KEY_MODE_128;
            wc_reg      <= 6'd0;
            rci_reg     <= 4'd1;
            pos_reg     <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wc_reg      <= wc_next;
            rci_reg     <= rci_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
        end
        prev_reg   <= prev_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    `AKE_ASSERT_NEXT(a_echo_word, aclk, aresetn, in_accept,
        m_tvalid && m_tdata == $past(s_tdata) && !m_tlast,
        "key word was not echoed on the master side")
    `AKE_ASSERT_NOW(a_last_index, aclk, aresetn, m_tvalid && m_tlast,
        m_tuser == last_index(mode_reg),
        "final word flagged at the wrong schedule position")
    `AKE_ASSERT_NEXT(a_done_clears, aclk, aresetn,
        state_reg == ST_CALC && out_free && is_last,
        wc_reg == 6'd0 && rci_reg == 4'd1 && state_reg == ST_IDLE,
        "schedule state not restored after the final word")
    `AKE_ASSERT_NOW(a_pos_range, aclk, aresetn, state_reg != ST_IDLE,
        {1'b0, pos_reg} < nk,
        "position within key length out of range")

endmodule

// ----- test/tb_aes_key_expansion.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES key expansion testbench
// Loads 128-, 192- and 256-bit keys word by word, including partial loads
// across key size changes, and compares every echoed and generated schedule
// word with a behavioral key schedule kept in a scoreboard. Both stream sides
// idle and stall at random, at rates set in three phases; the last has none.
// ----------------------------------------------------------------------------
module tb_aes_key_expansion;
    import aeske_pkg::*;

    // The spare key size code, which the block treats as a 256-bit key.
    localparam key_mode_t KEY_MODE_SPARE = 2'd3;
    localparam int        RANDOM_WORDS   = 104;
    localparam int        REPORT_LINES   = 40;

    typedef struct {
        word_t     round_word;
        word_idx_t word_index;
        logic      final_word;
    } sched_word_t;

    // ------------------------------------------------------------------------
    // Scoreboard: a behavioral key schedule and the queue of words it expects.
    // ------------------------------------------------------------------------
    class key_schedule_scoreboard;
        logic [7:0]  sbox [256];
        logic [7:0]  rcon [16];
        word_t       window [8];
        int unsigned loaded;
        int unsigned rcon_idx;
        key_mode_t   mode;
        sched_word_t expected [$];
        int          errors;

        function new();
            logic [7:0] inv, rot, s, v;
            for (int x = 0; x < 256; x++) begin
                inv = 8'h00;
                for (int y = 1; y < 256; y++) begin
                    if (gf_mul(x[7:0], y[7:0]) == 8'h01) begin
                        inv = y[7:0];
                    end
                end
                // Affine transform of the field inverse.
                s   = inv;
                rot = inv;
                for (int k = 0; k < 4; k++) begin
                    rot = {rot[6:0], rot[7]};
                    s   = s ^ rot;
                end
                sbox[x] = s ^ 8'h63;
            end
            v = 8'h01;
            foreach (rcon[k]) begin
                rcon[k] = 8'h00;
                if (k >= 1 && k <= 10) begin
                    rcon[k] = v;
                    v = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
                end
            end
            loaded   = 0;
            rcon_idx = 1;
            mode     = KEY_MODE_128;
            errors   = 0;
        endfunction

        function logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
            logic [7:0] p;
            p = 8'h00;
            for (int k = 0; k < 8; k++) begin
                if (b[0]) begin
                    p = p ^ a;
                end
                a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
                b = b >> 1;
            end
            return p;
        endfunction

        function word_t substitute(input word_t w);
            word_t r;
            for (int k = 0; k < 4; k++) begin
                r[8*k +: 8] = sbox[w[8*k +: 8]];
            end
            return r;
        endfunction

        function int unsigned key_length();
            case (mode)
                KEY_MODE_128: return 4;
                KEY_MODE_192: return 6;
                default:      return 8;
            endcase
        endfunction

        function void set_mode(input key_mode_t m);
            mode = m;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        // Queues the echo of an accepted key word and, when it completes the
        // key, every remaining word of the schedule.
        function void note_key_word(input word_t w);
            int unsigned nk, total, i;
            word_t       t, nw;
            sched_word_t e;
            nk    = key_length();
            total = 4 * (nk + 7);
            // A key size that shrank to or below the words already loaded restarts
            // the key at this word.
            if (loaded >= nk) begin
                loaded   = 0;
                rcon_idx = 1;
            end
            window[loaded % 8] = w;
            e.round_word = w;
            e.word_index = word_idx_t'(loaded);
            e.final_word = 1'b0;
            expected.push_back(e);
            loaded++;
            if (loaded < nk) begin
                return;
            end
            while (loaded < total) begin
                i = loaded;
                t = window[(i - 1) % 8];
                if (i % nk == 0) begin
                    t = substitute({t[23:0], t[31:24]}) ^ {rcon[rcon_idx], 24'h000000};
                    rcon_idx = (rcon_idx + 1) % 16;
                end else if (nk == 8 && i % nk == 4) begin
                    t = substitute(t);
                end
                nw = window[(i - nk) % 8] ^ t;
                window[i % 8] = nw;
                e.round_word = nw;
                e.word_index = word_idx_t'(i);
                e.final_word = (i == total - 1);
                expected.push_back(e);
                loaded++;
            end
            loaded   = 0;
            rcon_idx = 1;
        endfunction

        task report_mismatch(input string msg);
            if (errors < REPORT_LINES) begin
                $display("%0t ns: mismatch: %s", $realtime, msg);
            end
            errors++;
        endtask

        task check_result(input word_t data, input word_idx_t idx, input logic last);
            sched_word_t e;
            if (expected.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h index %0d", data, idx));
                return;
            end
            e = expected.pop_front();
            if (data !== e.round_word) begin
                report_mismatch($sformatf("word %0d: round word %h, wanted %h",
                                          e.word_index, data, e.round_word));
            end
            if (idx !== e.word_index) begin
                report_mismatch($sformatf("word index %0d, wanted %0d", idx, e.word_index));
            end
            if (last !== e.final_word) begin
                report_mismatch($sformatf("word %0d: last flag %b, wanted %b",
                                          e.word_index, last, e.final_word));
            end
        endtask
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_wdata = 2'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = 32'h0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [5:0]  m_tuser;
    logic        m_tlast;

    key_schedule_scoreboard sb = new();
    int src_gap_pct    = 10;
    int sink_stall_pct = 70;

    aes_key_expansion u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Receiver: checks each accepted word and stalls at random.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser, m_tlast);
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_word(input word_t w);
        while ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sb.note_key_word(w);
    endtask

    // Waits until every expected word has come out, so the block is idle.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_mode(input key_mode_t m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        sb.set_mode(m);
        cfg_we <= 1'b0;
    endtask

    initial begin
        word_t       nist_key [4];
        int          words_sent;
        int unsigned burst;
        word_t       w;

        nist_key = '{32'h2b7e1516, 32'h28aed2a6, 32'habf71588, 32'h09cf4f3c};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Known 128-bit key, an all-zero 192-bit key and an all-ones key
        // under the spare code.
        write_mode(KEY_MODE_128);
        foreach (nist_key[k]) begin
            send_word(nist_key[k]);
        end
        settle_block();
        write_mode(KEY_MODE_192);
        repeat (6) send_word(32'h00000000);
        settle_block();
        write_mode(KEY_MODE_SPARE);
        repeat (8) send_word(32'hffffffff);

        // Growing the key size mid-load keeps loading; shrinking it to or below
        // the words already loaded starts a new key.
        settle_block();
        write_mode(KEY_MODE_128);
        repeat (2) send_word($urandom);
        settle_block();
        write_mode(KEY_MODE_256);
        repeat (2) send_word($urandom);
        settle_block();
        write_mode(KEY_MODE_128);
        repeat (4) send_word($urandom);

        // Mostly whole keys with random content, some cut short.
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            if (words_sent >= 2 * RANDOM_WORDS / 3) begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end else if (words_sent >= RANDOM_WORDS / 3) begin
                src_gap_pct    = 70;
                sink_stall_pct = 10;
            end
            if ($urandom_range(99) < 40) begin
                settle_block();
                write_mode(key_mode_t'($urandom_range(KEY_MODE_SPARE)));
            end
            burst = sb.key_length();
            if ($urandom_range(99) < 15) begin
                burst = $urandom_range(burst - 1, 1);
            end
            repeat (burst) begin
                w = $urandom;
                case ($urandom_range(15))
                    0:       w = 32'h00000000;
                    1:       w = 32'hffffffff;
                    default: ;
                endcase
                send_word(w);
                words_sent++;
            end
        end

        settle_block();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/aeske_pkg.sv
hdl/aeske_ram.sv
hdl/aes_key_expansion.sv
test/tb_aes_key_expansion.sv
